@@ sv/tma_pkg.sv @@
package tma_pkg;

  localparam int DEF_ELEMENT_WIDTH = 32;
  localparam int DEF_CORDIC_STEPS  = 16;
  localparam int FRAC_BITS         = 16;
  localparam int ONE_Q16           = 65536;
  localparam int FULL_TURN         = 23592960;
  localparam int HALF_TURN         = 11796480;
  localparam int QUARTER_TURN      = 5898240;
  localparam int CORDIC_GAIN       = 652032874;
  localparam int CORDIC_W          = 34;
  localparam int TERM_W            = 32;
  localparam int TURN_SHIFTS       = 7;   // full-turn multiples tried, 64 down to 1

  typedef enum logic [2:0] {
    ACT_IDENTITY  = 3'd0,
    ACT_FILL      = 3'd1,
    ACT_ROT_X     = 3'd2,
    ACT_ROT_Y     = 3'd3,
    ACT_ROT_Z     = 3'd4,
    ACT_TRANSLATE = 3'd5,
    ACT_SCALE     = 3'd6,
    ACT_READ      = 3'd7
  } action_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;       // capture input item
    logic       reduce;     // angle reduction step
    logic       fold;       // wrap and fold the reduced angle
    logic       cordic;     // one cordic iteration
    logic       finish_sc;  // round sine and cosine
    logic       direct;     // identity, fill or scale write
    logic       mac;        // one multiply-accumulate
    logic       mac_last;   // last term of an element
    logic       commit;     // copy product into the matrix
    logic [4:0] step;       // cordic step number
    logic [3:0] elem;       // element of the product
    logic [1:0] k;          // term within element
  } tma_cmd_t;

  // arctangent table, degrees in Q16.16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0:  atan_deg = 22'd2949120;
      5'd1:  atan_deg = 22'd1740967;
      5'd2:  atan_deg = 22'd919879;
      5'd3:  atan_deg = 22'd466945;
      5'd4:  atan_deg = 22'd234379;
      5'd5:  atan_deg = 22'd117304;
      5'd6:  atan_deg = 22'd58666;
      5'd7:  atan_deg = 22'd29335;
      5'd8:  atan_deg = 22'd14668;
      5'd9:  atan_deg = 22'd7334;
      5'd10: atan_deg = 22'd3667;
      5'd11: atan_deg = 22'd1833;
      5'd12: atan_deg = 22'd917;
      5'd13: atan_deg = 22'd458;
      5'd14: atan_deg = 22'd229;
      5'd15: atan_deg = 22'd115;
      5'd16: atan_deg = 22'd57;
      5'd17: atan_deg = 22'd29;
      5'd18: atan_deg = 22'd14;
      5'd19: atan_deg = 22'd7;
      5'd20: atan_deg = 22'd4;
      5'd21: atan_deg = 22'd2;
      5'd22: atan_deg = 22'd1;
      default: atan_deg = 22'd0;
    endcase
  endfunction

endpackage

@@ sv/tma_ctrl.sv @@
module tma_ctrl
  import tma_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] action,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output tma_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_REDUCE, S_FOLD, S_CORDIC, S_FINISH, S_MAC, S_COMMIT, S_DIRECT, S_OUT
  } state_t;

  state_t     state;
  logic [4:0] step;
  logic [3:0] elem;
  logic [1:0] k;

  assign in_ready  = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd           = '0;
    cmd.step      = step;
    cmd.elem      = elem;
    cmd.k         = k;
    cmd.load      = in_valid && in_ready;
    cmd.reduce    = (state == S_REDUCE);
    cmd.fold      = (state == S_FOLD);
    cmd.cordic    = (state == S_CORDIC);
    cmd.finish_sc = (state == S_FINISH);
    cmd.direct    = (state == S_DIRECT);
    cmd.mac       = (state == S_MAC);
    cmd.mac_last  = (state == S_MAC) && (k == 2'd3);
    cmd.commit    = (state == S_COMMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      elem      <= '0;
      k         <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            step <= '0;
            elem <= '0;
            k    <= '0;
            case (action_t'(action))
              ACT_ROT_X, ACT_ROT_Y, ACT_ROT_Z: state <= S_REDUCE;
              ACT_TRANSLATE: state <= S_MAC;
              ACT_READ: state <= S_OUT;
              default: state <= S_DIRECT;
            endcase
          end
        end
        S_REDUCE: begin
          if (step == 5'(TURN_SHIFTS - 1)) begin
            step  <= '0;
            state <= S_FOLD;
          end else begin
            step <= step + 5'd1;
          end
        end
        S_FOLD: state <= S_CORDIC;
        S_CORDIC: begin
          step <= step + 5'd1;
          if (step == 5'(CORDIC_STEPS - 1)) state <= S_FINISH;
        end
        S_FINISH: state <= S_MAC;
        S_MAC: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            elem <= elem + 4'd1;
            if (elem == 4'd15) state <= S_COMMIT;
          end
        end
        S_COMMIT, S_DIRECT: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_after_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_valid) else $error("result not raised");
  a_mac_k: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> (k == 2'd0 && elem == 4'd0)) else $error("mac count off");
`endif

endmodule

@@ sv/tma_datapath.sv @@
module tma_datapath
  import tma_pkg::*;
#(
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  tma_cmd_t           cmd,
  input  logic [2:0]         action,
  input  logic signed [31:0] angle_deg,
  input  logic signed [31:0] x_term,
  input  logic signed [31:0] y_term,
  input  logic signed [31:0] z_term,
  input  logic [3:0]         element_index,
  output logic signed [31:0] element_value,
  output logic               saturated
);

  localparam int EW   = ELEMENT_WIDTH;
  localparam int PW   = EW + TERM_W + 1;   // full product width
  localparam int AW   = 36;                // cordic angle accumulator width
  localparam logic signed [EW:0] EMAX = (EW+1)'((65'sd1 <<< (EW - 1)) - 1);
  localparam logic signed [EW:0] EMIN = -EMAX - (EW+1)'(1);

  logic signed [EW-1:0] m    [16];
  logic signed [EW-1:0] nm   [16];
  action_t              act;
  logic signed [31:0]   xt, yt, zt;
  logic [3:0]           idx;
  logic                 flag, flip;
  logic signed [AW-1:0] a;
  logic signed [CORDIC_W-1:0] cx, cy;
  logic signed [17:0]   s_q, c_q;
  logic signed [EW-1:0] acc;
  logic signed [EW:0]   prod_r;
  logic                 prod_v, prod_last, prod_sat;
  logic [3:0]           prod_elem;
  logic [32:0]          au;        // angle magnitude being reduced
  logic                 aneg;      // angle sign

  function automatic logic signed [EW-1:0] clampw(input logic signed [63:0] v,
                                                  output logic f);
    f = 1'b0;
    if (v > 64'(EMAX)) begin f = 1'b1; clampw = EW'(EMAX); end
    else if (v < 64'(EMIN)) begin f = 1'b1; clampw = EW'(EMIN); end
    else clampw = EW'(v);
  endfunction

  function automatic logic signed [17:0] to_q16(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + CORDIC_W'(8192)) >>> 14;
    if (r > CORDIC_W'(ONE_Q16)) to_q16 = 18'(ONE_Q16);
    else if (r < -CORDIC_W'(ONE_Q16)) to_q16 = -18'(ONE_Q16);
    else to_q16 = 18'(r);
  endfunction

  // right-hand matrix term for element k of column col
  logic signed [31:0] rterm;
  logic [1:0]         col;
  logic [3:0]         ridx;
  assign col  = cmd.elem[1:0];
  assign ridx = {cmd.k, col};
  always_comb begin
    rterm = (ridx == 4'd0 || ridx == 4'd5 || ridx == 4'd10 || ridx == 4'd15)
            ? 32'sd65536 : 32'sd0;
    case (act)
      ACT_ROT_X: begin
        if (ridx == 4'd5 || ridx == 4'd10) rterm = 32'(c_q);
        if (ridx == 4'd6) rterm = -32'(s_q);
        if (ridx == 4'd9) rterm = 32'(s_q);
      end
      ACT_ROT_Y: begin
        if (ridx == 4'd0 || ridx == 4'd10) rterm = 32'(c_q);
        if (ridx == 4'd2) rterm = 32'(s_q);
        if (ridx == 4'd8) rterm = -32'(s_q);
      end
      ACT_ROT_Z: begin
        if (ridx == 4'd0 || ridx == 4'd5) rterm = 32'(c_q);
        if (ridx == 4'd1) rterm = -32'(s_q);
        if (ridx == 4'd4) rterm = 32'(s_q);
      end
      ACT_TRANSLATE: begin
        if (ridx == 4'd12) rterm = xt;
        if (ridx == 4'd13) rterm = yt;
        if (ridx == 4'd14) rterm = zt;
      end
      default: ;
    endcase
  end

  // shared multiplier: rounded, saturated product registered
  logic signed [EW-1:0] mop;
  logic signed [PW-1:0] p_full;
  logic signed [PW-1:0] p_abs;
  logic                 p_neg;
  logic [PW-1:0]        q;
  logic signed [EW:0]   p_sat;
  logic                 p_sf;
  assign mop    = m[{cmd.elem[3:2], cmd.k}];
  assign p_full = PW'(mop) * PW'(rterm);
  always_comb begin
    p_neg = p_full < 0;
    p_abs = p_neg ? -p_full : p_full;
    q     = (PW'(p_abs) + PW'(32768)) >> FRAC_BITS;
    p_sf  = 1'b0;
    if (p_neg) begin
      if (q > PW'(EMAX) + PW'(1)) begin p_sf = 1'b1; p_sat = EMIN; end
      else p_sat = -(EW+1)'(q);
    end else begin
      if (q > PW'(EMAX)) begin p_sf = 1'b1; p_sat = EMAX; end
      else p_sat = (EW+1)'(q);
    end
  end

  logic signed [EW+1:0] sum;
  logic signed [EW-1:0] sum_c;
  logic                 sum_f;
  assign sum   = (EW+2)'(acc) + (EW+2)'(prod_r);
  always_comb begin
    sum_f = 1'b0;
    if (sum > (EW+2)'(EMAX)) begin sum_f = 1'b1; sum_c = EW'(EMAX); end
    else if (sum < (EW+2)'(EMIN)) begin sum_f = 1'b1; sum_c = EW'(EMIN); end
    else sum_c = EW'(sum);
  end

  // cordic step
  logic signed [AW-1:0] atn;
  assign atn = AW'($signed({1'b0, atan_deg(cmd.step)}));

  // angle reduction: compare and subtract 64, 32 .. 1 full turns from the magnitude
  logic [32:0] turn_mult;
  assign turn_mult = 33'(FULL_TURN) << (3'(TURN_SHIFTS - 1) - cmd.step[2:0]);

  // remainder back to (-180, 180]
  logic signed [AW-1:0] red;
  always_comb begin
    red = (aneg && au != '0) ? AW'(FULL_TURN) - $signed(AW'(au)) : $signed(AW'(au));
    if (red > AW'(HALF_TURN)) red = red - AW'(FULL_TURN);
  end

  logic f1, f2, f3, fy;
  logic signed [EW-1:0] one_c, xc, yc, zc;
  always_comb begin
    one_c = clampw(64'(ONE_Q16), f1);
    xc    = clampw(64'(xt), f2);
    yc    = clampw(64'(yt), fy);
    zc    = clampw(64'(zt), f3);
  end

  logic signed [63:0] m_out64;
  assign m_out64 = 64'(m[idx]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action_t'(action);
      au   <= angle_deg[31] ? 33'(-(33'(angle_deg))) : 33'(angle_deg);
      aneg <= angle_deg[31];
      xt   <= x_term;
      yt   <= y_term;
      zt   <= z_term;
      idx  <= element_index;
      flag <= 1'b0;
      acc  <= '0;
    end
    if (cmd.reduce) begin
      if (au >= turn_mult) au <= au - turn_mult;
    end
    if (cmd.fold) begin
      flip <= (red > AW'(QUARTER_TURN)) || (red < -AW'(QUARTER_TURN));
      if (red > AW'(QUARTER_TURN)) a <= red - AW'(HALF_TURN);
      else if (red < -AW'(QUARTER_TURN)) a <= red + AW'(HALF_TURN);
      else a <= red;
      cx <= CORDIC_W'(CORDIC_GAIN);
      cy <= '0;
    end
    if (cmd.cordic) begin
      if (a >= 0) begin
        cx <= cx - (cy >>> cmd.step);
        cy <= cy + (cx >>> cmd.step);
        a  <= a - atn;
      end else begin
        cx <= cx + (cy >>> cmd.step);
        cy <= cy - (cx >>> cmd.step);
        a  <= a + atn;
      end
    end
    if (cmd.finish_sc) begin
      c_q <= flip ? -to_q16(cx) : to_q16(cx);
      s_q <= flip ? -to_q16(cy) : to_q16(cy);
    end
    // pipeline: product register feeds the accumulator in the next cycle
    prod_v    <= cmd.mac;
    prod_last <= cmd.mac_last;
    prod_elem <= cmd.elem;
    prod_r    <= p_sat;
    prod_sat  <= p_sf;
    if (prod_v) begin
      flag <= flag | prod_sat | sum_f;
      if (prod_last) begin
        nm[prod_elem] <= sum_c;
        acc <= '0;
      end else begin
        acc <= sum_c;
      end
    end
    if (rst) begin
      for (int i = 0; i < 16; i++) m[i] <= (i % 5 == 0) ? one_c : '0;
    end else if (cmd.commit) begin
      // last product lands this cycle too
      for (int i = 0; i < 16; i++) m[i] <= (prod_v && prod_last && 4'(i) == prod_elem)
                                           ? sum_c : nm[i];
    end else if (cmd.direct) begin
      for (int i = 0; i < 16; i++) begin
        if (act == ACT_FILL) m[i] <= xc;
        else if (act == ACT_SCALE && i == 0) m[i] <= xc;
        else if (act == ACT_SCALE && i == 5) m[i] <= yc;
        else if (act == ACT_SCALE && i == 10) m[i] <= zc;
        else m[i] <= (i % 5 == 0) ? one_c : '0;
      end
      if (act == ACT_FILL) flag <= f2;
      else if (act == ACT_SCALE) flag <= f1 | f2 | f3 | fy;
      else flag <= f1;
    end
  end

  always_comb begin
    if (m_out64 > 64'sd2147483647) element_value = 32'sh7fffffff;
    else if (m_out64 < -64'sd2147483648) element_value = 32'sh80000000;
    else element_value = 32'(m_out64);
  end
  assign saturated = flag;

endmodule

@@ sv/transform_matrix_accumulator.sv @@
// 4x4 homogeneous transform matrix accumulator, signed Q16.16 elements
// input channel s_axis: one command transaction per item (action, angle, terms,
// element index); output channel m_axis: one transaction per item with the
// selected element after the command and a saturation flag in tuser
// one item at a time; translate runs 64 multiply-accumulates on one shared
// multiplier plus commit; rotations run angle reduction, one cordic iteration
// a cycle, rounding, then the 64 macs
// s_axis_tready is low from acceptance until the result transaction is taken
// when the receiver stalls, the result holds in the output register and no
// new command is taken
// reset (rst, synchronous) loads the identity matrix and empties the output
module transform_matrix_accumulator
  import tma_pkg::*;
#(
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
  parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[2:0], angle_deg[34:3], x_term[66:35], y_term[98:67], z_term[130:99],
  // element_index[134:131], zero fill
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // element_value[31:0]
  output logic [31:0]  m_axis_tdata,
  // saturated[0]
  output logic         m_axis_tuser
);

  tma_cmd_t cmd;

  tma_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .action    (s_axis_tdata[2:0]),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // result value and flag are held in datapath registers until next command
  tma_datapath #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (s_axis_tdata[2:0]),
    .angle_deg     (s_axis_tdata[34:3]),
    .x_term        (s_axis_tdata[66:35]),
    .y_term        (s_axis_tdata[98:67]),
    .z_term        (s_axis_tdata[130:99]),
    .element_index (s_axis_tdata[134:131]),
    .element_value (m_axis_tdata),
    .saturated     (m_axis_tuser)
  );

endmodule

@@ tb/sv/tb_transform_matrix_accumulator.sv @@
module tb_transform_matrix_accumulator;
  import tma_pkg::*;

  localparam int  RANDOM_ITEMS = 1630;
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam int  HOLD_CYCLES  = 400;

  typedef struct {
    action_t     act;
    logic [31:0] angle;
    logic [31:0] xt;
    logic [31:0] yt;
    logic [31:0] zt;
    logic [3:0]  idx;
    bit          typed;   // expected result written in the row
    logic [31:0] val;
    bit          sat;
  } cmd_row_t;

  typedef struct {
    logic [31:0] val;
    bit          sat;
  } elem_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;

  longint       mat [16];       // predicted matrix
  elem_result_t pending_q[$];   // element results still to arrive
  int           mismatches = 0;
  int           results_seen = 0;
  int           sent = 0;
  int           sat_seen = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  int           cycles = 0;

  transform_matrix_accumulator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- predictor ----------------

  function automatic longint el_clamp(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // q16 product: round magnitude half away from zero, clamp to element range
  function automatic longint q16_mul(longint a, longint b, inout bit f);
    longint unsigned ma, mb, q, lim;
    bit neg;
    ma  = (a < 0) ? longint'(-a) : longint'(a);
    mb  = (b < 0) ? longint'(-b) : longint'(b);
    neg = (a < 0) != (b < 0);
    q   = (ma * mb + 64'd32768) >> 16;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (q > lim) begin
      f = 1'b1;
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint round_q16(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > ONE_Q16) r = ONE_Q16;
    if (r < -ONE_Q16) r = -ONE_Q16;
    return r;
  endfunction

  // cordic sine and cosine of an angle in q16.16 degrees
  function automatic void sin_cos_deg(longint deg, output longint s, output longint c);
    longint a, x, y, dx, dy;
    bit flip;
    a = deg % FULL_TURN;
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    if (a < 0) a += FULL_TURN;
    if (a > HALF_TURN) a -= FULL_TURN;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= longint'(atan_deg(i[4:0]));
      end else begin
        x += dx; y -= dy; a += longint'(atan_deg(i[4:0]));
      end
    end
    c = round_q16(x);
    s = round_q16(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? ONE_Q16 : 0;
  endfunction

  function automatic void post_multiply(longint r [16], inout bit f);
    longint nm [16];
    longint acc;
    for (int row = 0; row < 4; row++)
      for (int col = 0; col < 4; col++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc = el_clamp(acc + q16_mul(mat[row*4+k], r[k*4+col], f), f);
        nm[row*4+col] = acc;
      end
    for (int k = 0; k < 16; k++) mat[k] = nm[k];
  endfunction

  // apply one command to the predicted matrix, return the selected element
  function automatic elem_result_t apply_command(cmd_row_t c);
    elem_result_t res;
    longint r [16];
    longint s, co, v;
    bit f;
    f = 1'b0;
    for (int i = 0; i < 16; i++) r[i] = (i % 5 == 0) ? ONE_Q16 : 0;
    case (c.act)
      ACT_IDENTITY: load_identity();
      ACT_FILL: begin
        v = longint'($signed(c.xt));
        for (int i = 0; i < 16; i++) mat[i] = v;
      end
      ACT_ROT_X, ACT_ROT_Y, ACT_ROT_Z: begin
        sin_cos_deg(longint'($signed(c.angle)), s, co);
        if (c.act == ACT_ROT_X) begin
          r[5] = co; r[6] = -s; r[9] = s; r[10] = co;
        end else if (c.act == ACT_ROT_Y) begin
          r[0] = co; r[2] = s; r[8] = -s; r[10] = co;
        end else begin
          r[0] = co; r[1] = -s; r[4] = s; r[5] = co;
        end
        post_multiply(r, f);
      end
      ACT_TRANSLATE: begin
        r[12] = $signed(c.xt);
        r[13] = $signed(c.yt);
        r[14] = $signed(c.zt);
        post_multiply(r, f);
      end
      ACT_SCALE: begin
        load_identity();
        mat[0]  = $signed(c.xt);
        mat[5]  = $signed(c.yt);
        mat[10] = $signed(c.zt);
      end
      default: ;
    endcase
    res.val = mat[c.idx][31:0];
    res.sat = f;
    return res;
  endfunction

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    elem_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser) sat_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: value %h sat %b", m_axis_tdata,
                   m_axis_tuser);
      end else begin
        e = pending_q.pop_front();
        if (e.val !== m_axis_tdata || e.sat !== m_axis_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected value %h sat %b, got value %h sat %b",
                     results_seen, e.val, e.sat, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  // ---------------- receiver stalls ----------------

  always @(posedge clk) begin
    int unsigned p;
    p = $urandom_range(0, 99);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      // long hold-off: the block keeps its result and refuses new commands
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && sent >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (sent > 1200 && sent < 1350) begin
      m_axis_tready <= 1'b1;   // stretch with no stalls
    end else if (p < 3) begin
      hold_left <= $urandom_range(20, 60);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (p < 70);
    end
  end

  // ---------------- timeout ----------------

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  cmd_row_t directed [] = '{
    // after reset: diagonal is one, off-diagonal zero
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 32'h0, 4'd0, 1, 32'h0001_0000, 0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 32'h0, 4'd1, 1, 32'h0, 0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 32'h0, 4'd15, 1, 32'h0001_0000, 0},
    // quarter, half and three-quarter turns, applied in sequence from the identity
    '{ACT_ROT_Z, 32'h005A_0000, 32'h0, 32'h0, 32'h0, 4'd1, 0, 32'h0, 0},
    '{ACT_ROT_X, 32'hFFA6_0000, 32'h0, 32'h0, 32'h0, 4'd6, 0, 32'h0, 0},
    '{ACT_ROT_Y, 32'h00B4_0000, 32'h0, 32'h0, 32'h0, 4'd2, 0, 32'h0, 0},
    '{ACT_ROT_Z, 32'hFF4C_0000, 32'h0, 32'h0, 32'h0, 4'd5, 0, 32'h0, 0},
    '{ACT_ROT_X, 32'h010E_0000, 32'h0, 32'h0, 32'h0, 4'd9, 0, 32'h0, 0},
    // angle extremes, then a translation and a return to identity
    '{ACT_ROT_Y, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 4'd8, 0, 32'h0, 0},
    '{ACT_ROT_Z, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 4'd4, 0, 32'h0, 0},
    '{ACT_TRANSLATE, 32'h0, 32'h0003_8000, 32'hFFFE_0000, 32'h0000_0001, 4'd12, 0, 32'h0, 0},
    '{ACT_IDENTITY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd10,
      1, 32'h0001_0000, 0},
    // translations with term extremes, the second one saturating
    '{ACT_TRANSLATE, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 4'd13, 0, 32'h0, 0},
    '{ACT_TRANSLATE, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 4'd14, 0, 32'h0, 0},
    // fill extremes
    '{ACT_FILL, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 4'd7, 1, 32'h7FFF_FFFF, 0},
    '{ACT_ROT_X, 32'h002D_0000, 32'h0, 32'h0, 32'h0, 4'd5, 0, 32'h0, 0},
    '{ACT_FILL, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 4'd3, 1, 32'h8000_0000, 0},
    '{ACT_ROT_Y, 32'h001E_0000, 32'h0, 32'h0, 32'h0, 4'd0, 0, 32'h0, 0},
    '{ACT_TRANSLATE, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4'd15, 0, 32'h0, 0},
    // scale replaces the matrix
    '{ACT_SCALE, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 4'd0,
      1, 32'h7FFF_FFFF, 0},
    '{ACT_READ, 32'h0, 32'h0, 32'h0, 32'h0, 4'd5, 1, 32'h8000_0000, 0},
    '{ACT_ROT_Z, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 4'd1, 0, 32'h0, 0},
    '{ACT_FILL, 32'h0, 32'h0, 32'h0, 32'h0, 4'd11, 1, 32'h0, 0},
    '{ACT_IDENTITY, 32'h0, 32'h0, 32'h0, 32'h0, 4'd4, 1, 32'h0, 0}
  };

  function automatic logic [31:0] rand_small(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic cmd_row_t random_command();
    cmd_row_t c;
    int unsigned p, wide;
    p = $urandom_range(0, 99);
    wide = $urandom_range(0, 9);
    c.typed = 1'b0;
    c.val = '0;
    c.sat = 1'b0;
    c.idx = 4'($urandom_range(0, 15));
    c.angle = (wide == 0) ? $urandom() : rand_small(32'h0168_0000);
    c.xt = (wide == 0) ? $urandom() : rand_small(32'h0010_0000);
    c.yt = (wide == 0) ? $urandom() : rand_small(32'h0010_0000);
    c.zt = (wide == 0) ? $urandom() : rand_small(32'h0010_0000);
    if (p < 10)      c.act = ACT_READ;
    else if (p < 15) c.act = ACT_IDENTITY;
    else if (p < 18) c.act = ACT_FILL;
    else if (p < 25) begin
      c.act = ACT_SCALE;
      if (wide != 0) begin
        c.xt = rand_small(32'h0002_0000);
        c.yt = rand_small(32'h0002_0000);
        c.zt = rand_small(32'h0002_0000);
      end
    end
    else if (p < 42) c.act = ACT_ROT_X;
    else if (p < 59) c.act = ACT_ROT_Y;
    else if (p < 75) c.act = ACT_ROT_Z;
    else             c.act = ACT_TRANSLATE;
    return c;
  endfunction

  // offer one command; returns once the transaction is accepted
  task automatic send_command(cmd_row_t c);
    elem_result_t e;
    int unsigned g;
    g = $urandom_range(0, 99);
    if (sent > 1200 && sent < 1350) g = 0;
    else if (g < 55) g = 0;
    else if (g < 95) g = $urandom_range(1, 4);
    else g = $urandom_range(10, 60);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, c.idx, c.zt, c.yt, c.xt, c.angle, c.act};
    do @(posedge clk); while (!s_axis_tready);
    e = apply_command(c);
    if (c.typed) begin
      e.val = c.val;
      e.sat = c.sat;
    end
    pending_q.push_back(e);
    sent++;
  endtask

  initial begin
    int wait_cycles;
    load_identity();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_command(directed[i]);
    for (int n = 0; n < RANDOM_ITEMS; n++) send_command(random_command());
    s_axis_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    // output register is empty once the last result is taken; wait idle before reporting
    wait_cycles = 0;
    while (wait_cycles < 100) begin
      @(posedge clk);
      wait_cycles++;
    end

    $display("sent %0d commands (%0d directed), checked %0d results, %0d with saturation",
             sent, directed.size(), results_seen, sat_seen);
    $display("receiver hold-off of %0d cycles exercised, %0d mismatches", HOLD_CYCLES,
             mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
